>>> hw/rtl/jsu_pkg.sv
// Shared types and codes for the JSON string unescaper.
package jsu_pkg;

  localparam int BYTE_W = 8;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [1:0]        status_t;

  localparam status_t ST_DATA = 2'd0;
  localparam status_t ST_END  = 2'd1;
  localparam status_t ST_ERR  = 2'd2;

  // Up to three result bytes produced by one input byte.
  typedef struct packed {
    logic [1:0] cnt;
    status_t    status;
    byte_t      b0;
    byte_t      b1;
    byte_t      b2;
  } burst_t;

endpackage

>>> hw/rtl/jsu_if.sv
// Valid/ready channel interfaces for the input bytes and the decoded results.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

>>> hw/rtl/json_string_unescape_utf8_top.sv
// Each byte passes the input register and the decoder into the result register.
// Throughput: one byte per cycle when the output is ready; a \u escape of 2 or 3
//   UTF-8 bytes holds the input while the result register shifts them out.
// Bytes with no result (backslash, u, first hex digits) load an empty burst.
// Reset (synchronous, rst_n low) empties both registers and returns to text mode.
module json_string_unescape_utf8_top import jsu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);

  logic   in_vld_r;
  byte_t  in_byte_r;
  logic   can_load;
  logic   take;
  burst_t burst;

  assign take        = in_vld_r && can_load;
  assign in_ch.ready = !in_vld_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_vld_r <= 1'b1;
    end else if (take) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.in_byte;
    end
  end

  jsu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (take),
    .in_byte (in_byte_r),
    .burst   (burst)
  );

  jsu_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (take),
    .burst    (burst),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule

>>> hw/rtl/jsu_decode.sv
// Escape state machine and UTF-8 encoder: one input byte to a burst of results.
module jsu_decode import jsu_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   fire,
  input  byte_t  in_byte,
  output burst_t burst
);

  localparam logic [2:0] MODE_TEXT = 3'd0;
  localparam logic [2:0] MODE_ESC  = 3'd1;
  localparam logic [2:0] MODE_HEX1 = 3'd2;
  localparam logic [2:0] MODE_HEX2 = 3'd3;
  localparam logic [2:0] MODE_HEX3 = 3'd4;
  localparam logic [2:0] MODE_HEX4 = 3'd5;

  logic [2:0]  mode_r, mode_nxt;
  logic [11:0] hex_r, hex_nxt;
  logic        hex_ok;
  logic [3:0]  hex_dig;
  logic [15:0] cp;

  always_comb begin
    hex_ok  = 1'b1;
    hex_dig = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_dig = in_byte[3:0];
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      hex_dig = in_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cp = {hex_r, hex_dig};

  always_comb begin
    mode_nxt     = mode_r;
    hex_nxt      = hex_r;
    burst        = '0;
    burst.status = ST_DATA;
    unique case (mode_r)
      MODE_ESC: begin
        mode_nxt = MODE_TEXT;
        burst.cnt = 2'd1;
        if (in_byte == 8'h00) begin
          hex_nxt      = '0;
          burst.status = ST_ERR;
        end else begin
          unique case (in_byte)
            8'h74:   burst.b0 = 8'h09;
            8'h6E:   burst.b0 = 8'h0A;
            8'h62:   burst.b0 = 8'h08;
            8'h66:   burst.b0 = 8'h0C;
            8'h72:   burst.b0 = 8'h0D;
            8'h75: begin
              mode_nxt  = MODE_HEX1;
              hex_nxt   = '0;
              burst.cnt = 2'd0;
            end
            default: burst.b0 = in_byte;
          endcase
        end
      end
      MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
        if (!hex_ok) begin
          mode_nxt     = MODE_TEXT;
          hex_nxt      = '0;
          burst.cnt    = 2'd1;
          burst.status = ST_ERR;
        end else if (mode_r == MODE_HEX4) begin
          mode_nxt = MODE_TEXT;
          hex_nxt  = '0;
          if (cp < 16'h0080) begin
            burst.cnt = 2'd1;
            burst.b0  = cp[7:0];
          end else if (cp <= 16'h07FF) begin
            burst.cnt = 2'd2;
            burst.b0  = {3'b110, cp[10:6]};
            burst.b1  = {2'b10, cp[5:0]};
          end else begin
            burst.cnt = 2'd3;
            burst.b0  = {4'hE, cp[15:12]};
            burst.b1  = {2'b10, cp[11:6]};
            burst.b2  = {2'b10, cp[5:0]};
          end
        end else begin
          mode_nxt = mode_r + 3'd1;
          hex_nxt  = {hex_r[7:0], hex_dig};
        end
      end
      default: begin
        // Normal text; stray mode codes land here too.
        mode_nxt = MODE_TEXT;
        hex_nxt  = '0;
        if (in_byte == 8'h00) begin
          burst.cnt    = 2'd1;
          burst.status = ST_ERR;
        end else if (in_byte == 8'h22) begin
          burst.cnt    = 2'd1;
          burst.status = ST_END;
        end else if (in_byte == 8'h5C) begin
          mode_nxt = MODE_ESC;
        end else begin
          burst.cnt = 2'd1;
          burst.b0  = in_byte;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_TEXT;
      hex_r  <= '0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      hex_r  <= hex_nxt;
    end
  end

endmodule

>>> hw/rtl/jsu_out_buf.sv
// Result register: holds one burst and shifts its bytes out one per transaction.
module jsu_out_buf import jsu_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   load,
  input  burst_t burst,
  output logic   can_load,
  jsu_out_if.source out_ch
);

  logic [1:0] cnt_r;
  status_t    status_r;
  byte_t      b0_r, b1_r, b2_r;
  logic       pop;

  assign pop      = (cnt_r != 2'd0) && out_ch.ready;
  // Take a new burst once the last byte of the current one leaves.
  assign can_load = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ch.ready);

  assign out_ch.valid    = (cnt_r != 2'd0);
  assign out_ch.out_byte = b0_r;
  assign out_ch.status   = status_r;
  assign out_ch.last     = (cnt_r == 2'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= burst.cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= burst.status;
      b0_r     <= burst.b0;
      b1_r     <= burst.b1;
      b2_r     <= burst.b2;
    end else if (pop) begin
      b0_r <= b1_r;
      b1_r <= b2_r;
    end
  end

endmodule

>>> dv/json_string_unescape_utf8_top_test.sv
// Self-checking testbench for the JSON string unescaper: escapes, \u to UTF-8, ends and errors.
module json_string_unescape_utf8_top_test;
  import jsu_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;

  localparam byte_t CH_NUL   = 8'h00;
  localparam byte_t CH_QUOTE = 8'h22;
  localparam byte_t CH_BSL   = 8'h5C;
  localparam byte_t CH_T     = "t";
  localparam byte_t CH_N     = "n";
  localparam byte_t CH_B     = "b";
  localparam byte_t CH_F     = "f";
  localparam byte_t CH_R     = "r";
  localparam byte_t CH_U     = "u";
  localparam byte_t CTL_TAB  = 8'h09;
  localparam byte_t CTL_LF   = 8'h0A;
  localparam byte_t CTL_BS   = 8'h08;
  localparam byte_t CTL_FF   = 8'h0C;
  localparam byte_t CTL_CR   = 8'h0D;

  typedef enum logic [2:0] {
    SCAN_TEXT, SCAN_ESC, SCAN_HEX1, SCAN_HEX2, SCAN_HEX3, SCAN_HEX4
  } scan_t;

  typedef struct packed {
    byte_t   data;
    status_t status;
    logic    last;
  } result_t;

  logic clk;
  logic rst_n;

  jsu_in_if  in_ch();
  jsu_out_if out_ch();

  json_string_unescape_utf8_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  byte_t       raw_bytes[$];
  result_t     decoded_q[$];
  scan_t       scan_mode;
  logic [11:0] hex_acc;
  result_t     want;
  logic        in_fire;
  logic        out_fire;
  int          mismatches;
  int          idle_cycles;
  int          in_gap;
  int          in_calm;
  int          out_wait;
  int          out_calm;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Wait cycles for one transaction; now and then a run of items with no wait at all.
  task automatic draw_wait(inout int calm, output int cycles);
    if (calm > 0) begin
      calm--;
      cycles = 0;
    end else begin
      if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 32);
      cycles = $urandom_range(0, 15);
    end
  endtask

  function automatic int hex_nibble(input byte_t b);
    if (b >= "0" && b <= "9") return b - "0";
    if (b >= "a" && b <= "f") return b - "a" + 10;
    if (b >= "A" && b <= "F") return b - "A" + 10;
    return -1;
  endfunction

  task automatic push_result(input byte_t d, input status_t s, input logic l);
    decoded_q.push_back('{data: d, status: s, last: l});
  endtask

  task automatic flag_error();
    scan_mode = SCAN_TEXT;
    hex_acc   = '0;
    push_result('0, ST_ERR, 1'b1);
  endtask

  // Advance the decoder by one input byte and queue the results it yields.
  task automatic decode_byte(input byte_t b);
    int          nib;
    logic [15:0] cp;
    case (scan_mode)
      SCAN_ESC: begin
        if (b == CH_NUL) begin
          flag_error();
        end else begin
          scan_mode = SCAN_TEXT;
          case (b)
            CH_T: push_result(CTL_TAB, ST_DATA, 1'b1);
            CH_N: push_result(CTL_LF, ST_DATA, 1'b1);
            CH_B: push_result(CTL_BS, ST_DATA, 1'b1);
            CH_F: push_result(CTL_FF, ST_DATA, 1'b1);
            CH_R: push_result(CTL_CR, ST_DATA, 1'b1);
            CH_U: begin
              scan_mode = SCAN_HEX1;
              hex_acc   = '0;
            end
            default: push_result(b, ST_DATA, 1'b1);
          endcase
        end
      end
      SCAN_HEX1, SCAN_HEX2, SCAN_HEX3, SCAN_HEX4: begin
        nib = hex_nibble(b);
        if (nib < 0) begin
          flag_error();
        end else if (scan_mode == SCAN_HEX4) begin
          cp        = {hex_acc, nib[3:0]};
          scan_mode = SCAN_TEXT;
          hex_acc   = '0;
          if (cp < 16'h0080) begin
            push_result(cp[7:0], ST_DATA, 1'b1);
          end else if (cp <= 16'h07FF) begin
            push_result({3'b110, cp[10:6]}, ST_DATA, 1'b0);
            push_result({2'b10, cp[5:0]}, ST_DATA, 1'b1);
          end else begin
            push_result({4'b1110, cp[15:12]}, ST_DATA, 1'b0);
            push_result({2'b10, cp[11:6]}, ST_DATA, 1'b0);
            push_result({2'b10, cp[5:0]}, ST_DATA, 1'b1);
          end
        end else begin
          hex_acc   = {hex_acc[7:0], nib[3:0]};
          scan_mode = scan_t'(scan_mode + 3'd1);
        end
      end
      default: begin
        scan_mode = SCAN_TEXT;
        hex_acc   = '0;
        if (b == CH_NUL) flag_error();
        else if (b == CH_QUOTE) push_result('0, ST_END, 1'b1);
        else if (b == CH_BSL) scan_mode = SCAN_ESC;
        else push_result(b, ST_DATA, 1'b1);
      end
    endcase
  endtask

  function automatic byte_t hex_char(input logic [3:0] v);
    if (v < 4'd10) return "0" + v;
    return ($urandom_range(0, 1) ? "A" : "a") + v - 8'd10;
  endfunction

  function automatic byte_t non_hex_char();
    byte_t c;
    case ($urandom_range(0, 3))
      0: return CH_NUL;
      1: return CH_QUOTE;
      default: begin
        do c = byte_t'($urandom_range(0, 255)); while (hex_nibble(c) >= 0);
        return c;
      end
    endcase
  endfunction

  task automatic push_escape(input byte_t b);
    raw_bytes.push_back(CH_BSL);
    raw_bytes.push_back(b);
  endtask

  // Queue a \u escape; a bad digit replaces digit bad_pos and cuts the escape short.
  task automatic add_unicode(input logic [15:0] cp, input int bad_pos);
    raw_bytes.push_back(CH_BSL);
    raw_bytes.push_back(CH_U);
    for (int i = 0; i < 4; i++) begin
      if (i == bad_pos) begin
        raw_bytes.push_back(non_hex_char());
        return;
      end
      raw_bytes.push_back(hex_char(cp[15 - 4*i -: 4]));
    end
  endtask

  task automatic add_token();
    byte_t c;
    int    pick;
    pick = $urandom_range(0, 19);
    if (pick <= 6) begin
      do c = byte_t'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSL);
      raw_bytes.push_back(c);
    end else if (pick <= 8) begin
      case ($urandom_range(0, 4))
        0: push_escape(CH_T);
        1: push_escape(CH_N);
        2: push_escape(CH_B);
        3: push_escape(CH_F);
        default: push_escape(CH_R);
      endcase
    end else if (pick <= 10) begin
      do c = byte_t'($urandom_range(1, 255));
      while (c inside {CH_T, CH_N, CH_B, CH_F, CH_R, CH_U});
      push_escape(c);
    end else if (pick <= 14) begin
      case ($urandom_range(0, 3))
        0: add_unicode(16'($urandom_range(0, 16'h007F)), -1);
        1: add_unicode(16'($urandom_range(16'h0080, 16'h07FF)), -1);
        2: add_unicode(16'($urandom_range(16'h0800, 16'hFFFF)), -1);
        default: add_unicode(16'($urandom_range(16'hD800, 16'hDFFF)), -1);
      endcase
    end else if (pick <= 16) begin
      raw_bytes.push_back(CH_QUOTE);
    end else if (pick == 17) begin
      raw_bytes.push_back(CH_NUL);
    end else if (pick == 18) begin
      push_escape(CH_NUL);
    end else begin
      add_unicode(16'($urandom), $urandom_range(0, 3));
    end
  endtask

  task automatic wait_drained();
    while (raw_bytes.size() != 0 || in_ch.valid || decoded_q.size() != 0) @(negedge clk);
  endtask

  // Byte source: hold each byte until its transaction, then advance after the drawn gap.
  always @(negedge clk) begin
    if (in_fire || !in_ch.valid) begin
      if (in_gap > 0) begin
        in_ch.valid <= 1'b0;
        in_gap = in_gap - 1;
      end else if (raw_bytes.size() != 0) begin
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= raw_bytes.pop_front();
        draw_wait(in_calm, in_gap);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result sink: stall a drawn number of cycles after each transaction.
  always @(negedge clk) begin
    if (out_fire) draw_wait(out_calm, out_wait);
    if (out_wait > 0) begin
      out_ch.ready <= 1'b0;
      out_wait = out_wait - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    in_fire  <= in_ch.valid && in_ch.ready;
    out_fire <= out_ch.valid && out_ch.ready;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte %02h status %0d last %0b",
                                    out_ch.out_byte, out_ch.status, out_ch.last));
        end else begin
          want = decoded_q.pop_front();
          if (out_ch.out_byte !== want.data || out_ch.status !== want.status ||
              out_ch.last !== want.last) begin
            report_mismatch($sformatf("byte %02h status %0d last %0b, expected %02h %0d %0b",
                                      out_ch.out_byte, out_ch.status, out_ch.last,
                                      want.data, want.status, want.last));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.in_byte);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles = idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL json_string_unescape_utf8_top");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    out_ch.ready  = 1'b0;
    in_fire       = 1'b0;
    out_fire      = 1'b0;
    scan_mode     = SCAN_TEXT;
    hex_acc       = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    raw_bytes.push_back(8'h01);
    push_escape(CH_T);
    push_escape(CH_N);
    push_escape(CH_B);
    push_escape(CH_F);
    push_escape(CH_R);
    push_escape(8'hFF);
    raw_bytes.push_back(CH_QUOTE);
    raw_bytes.push_back(CH_NUL);
    push_escape(CH_NUL);
    add_unicode(16'hFFFF, -1);
    add_unicode(16'h0000, 1);
    wait_drained();

    // Two random phases with a full drain between them.
    @(posedge clk);
    while (raw_bytes.size() < 90) add_token();
    wait_drained();
    @(posedge clk);
    while (raw_bytes.size() < 90) add_token();
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("PASS json_string_unescape_utf8_top");
    else $display("FAIL json_string_unescape_utf8_top");
    $finish;
  end

endmodule
